[rtl/mrm_pkg.sv]
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared types, constants and helpers of the Modbus register map block.
// ----------------------------------------------------------------------------
package mrm_pkg;

    // field widths
    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 16;
    localparam int COUNT_W   = 11;
    localparam int OP_W      = 2;
    localparam int WIN_W     = 3;
    localparam int BIT_W     = 8;
    localparam int REG_W     = 16;
    localparam int NUM_WIN   = 4;
    localparam int CMP_W     = ADDR_W + 1;

    // default table depth per window
    localparam int DEF_WINDOW_DEPTH = 1024;

    // apb port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [2:0] REG_COIL_START     = 3'd0;
    localparam logic [2:0] REG_COIL_COUNT     = 3'd1;
    localparam logic [2:0] REG_DISCRETE_START = 3'd2;
    localparam logic [2:0] REG_DISCRETE_COUNT = 3'd3;
    localparam logic [2:0] REG_INREG_START    = 3'd4;
    localparam logic [2:0] REG_INREG_COUNT    = 3'd5;
    localparam logic [2:0] REG_HOLDING_START  = 3'd6;
    localparam logic [2:0] REG_HOLDING_COUNT  = 3'd7;

    // window slots in the configuration array
    localparam int SLOT_COIL     = 0;
    localparam int SLOT_DISCRETE = 1;
    localparam int SLOT_INREG    = 2;
    localparam int SLOT_HOLDING  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_QUERY = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [WIN_W-1:0] {
        WIN_NONE     = 3'd0,
        WIN_COIL     = 3'd1,
        WIN_DISCRETE = 3'd2,
        WIN_INREG    = 3'd3,
        WIN_HOLDING  = 3'd4
    } t_win;

    typedef enum logic [1:0] {
        BK_INIT,
        BK_RUN,
        BK_WAIT,
        BK_CLEAR
    } t_back_state;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_value;
        logic [WIN_W-1:0]  window_hit;
        logic              was_updated;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [COUNT_W-1:0] count;
    } t_win_cfg;

    typedef t_win_cfg [NUM_WIN-1:0] t_map_cfg;

    // classified transaction handed from front to back
    typedef struct packed {
        t_op               op;
        t_win              win;
        logic [ADDR_W-1:0] off;
        logic [DATA_W-1:0] val;
    } t_cmd;

    // one-hot table select of a window code
    function automatic logic [NUM_WIN-1:0] win_onehot(input t_win win);
        logic [NUM_WIN-1:0] sel;
        sel = '0;
        case (win)
            WIN_COIL:     sel[SLOT_COIL]     = 1'b1;
            WIN_DISCRETE: sel[SLOT_DISCRETE] = 1'b1;
            WIN_INREG:    sel[SLOT_INREG]    = 1'b1;
            WIN_HOLDING:  sel[SLOT_HOLDING]  = 1'b1;
            default:      sel = '0;
        endcase
        return sel;
    endfunction

endpackage

[rtl/mrm_ram.sv]
// ----------------------------------------------------------------------------
// mrm_ram
// Generic simple dual-port ram, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/mrm_front.sv]
// ----------------------------------------------------------------------------
// mrm_front
// Accepts transactions and decodes the address against the four windows.
// ----------------------------------------------------------------------------
module mrm_front
    import mrm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    input  t_map_cfg i_cfg,
    input  logic     i_q_full,
    output logic     o_in_stall,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam logic [CMP_W-1:0] DEPTH_LIM = CMP_W'(WINDOW_DEPTH);

    logic [ADDR_W-1:0]  diff [NUM_WIN];
    logic [NUM_WIN-1:0] hit;
    logic [CMP_W-1:0]   lim  [NUM_WIN];

    // per-window range check, count saturated to the table depth
    always_comb begin
        for (int k = 0; k < NUM_WIN; k++) begin
            diff[k] = i_in_data.address - i_cfg[k].start;
            lim[k]  = (CMP_W'(i_cfg[k].count) > DEPTH_LIM) ? DEPTH_LIM
                                                            : CMP_W'(i_cfg[k].count);
            hit[k]  = (i_in_data.address >= i_cfg[k].start) &&
                      ({1'b0, diff[k]} < lim[k]);
        end
    end

    // first matching window wins
    always_comb begin
        o_cmd.op  = t_op'(i_in_data.operation);
        o_cmd.val = i_in_data.write_value;
        o_cmd.win = WIN_NONE;
        o_cmd.off = '0;
        for (int k = NUM_WIN - 1; k >= 0; k--) begin
            if (hit[k]) begin
                o_cmd.win = t_win'(WIN_W'(k + 1));
                o_cmd.off = diff[k];
            end
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

[rtl/mrm_queue.sv]
// ----------------------------------------------------------------------------
// mrm_queue
// Short command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module mrm_queue
    import mrm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QLVL_W-1:0] r_level, n_level;

    // pointer and level update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_level = r_level;
        if (i_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_level = r_level + 1'b1;
        end else if (!i_push && i_pop) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_level <= n_level;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_full  = (r_level == QLVL_W'(QUEUE_DEPTH));
    assign o_valid = (r_level != '0);
    assign o_cmd   = r_mem[r_rptr];

endmodule

[rtl/mrm_back.sv]
// ----------------------------------------------------------------------------
// mrm_back
// Executes decoded transactions on the window tables and update marks.
// ----------------------------------------------------------------------------
module mrm_back
    import mrm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int            AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(WINDOW_DEPTH - 1);

    t_back_state      r_state, n_state;
    logic [AW-1:0]    r_cnt, n_cnt;
    t_cmd             r_cmd, n_cmd;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_data, n_out_data;

    logic               slot_free;
    logic               sweep_tbl;
    logic               sweep_mark;
    logic [NUM_WIN-1:0] tbl_we;
    logic [NUM_WIN-1:0] mark_we;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;
    logic [DATA_W-1:0]  tbl_wdata;
    logic               mark_wdata;
    logic [BIT_W-1:0]   rd_coil;
    logic [BIT_W-1:0]   rd_disc;
    logic [REG_W-1:0]   rd_inreg;
    logic [REG_W-1:0]   rd_hold;
    logic [NUM_WIN-1:0] rd_mark;
    logic [DATA_W-1:0]  rd_sel;

    assign slot_free = !r_out_valid || !i_out_stall;

    // table read data of the waiting command
    always_comb begin
        case (r_cmd.win)
            WIN_COIL:     rd_sel = DATA_W'(rd_coil);
            WIN_DISCRETE: rd_sel = DATA_W'(rd_disc);
            WIN_INREG:    rd_sel = rd_inreg;
            WIN_HOLDING:  rd_sel = rd_hold;
            default:      rd_sel = '0;
        endcase
    end

    // sequencer: clearing passes, dispatch and result loading
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        sweep_tbl   = 1'b0;
        sweep_mark  = 1'b0;
        tbl_we      = '0;
        mark_we     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            BK_INIT: begin
                sweep_tbl  = 1'b1;
                sweep_mark = 1'b1;
                tbl_we     = '1;
                mark_we    = '1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (i_cmd_valid && slot_free) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    unique case (i_cmd.op)
                        OP_WRITE: begin
                            tbl_we                = win_onehot(i_cmd.win);
                            mark_we               = win_onehot(i_cmd.win);
                            n_out_data.window_hit = i_cmd.win;
                        end
                        OP_READ, OP_QUERY: begin
                            if (i_cmd.win != WIN_NONE) begin
                                n_out_valid = 1'b0;
                                n_cmd       = i_cmd;
                                n_state     = BK_WAIT;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt   = '0;
                            n_state = BK_CLEAR;
                        end
                    endcase
                end
            end
            BK_WAIT: begin
                n_out_valid            = 1'b1;
                n_out_data             = '0;
                n_out_data.window_hit  = r_cmd.win;
                if (r_cmd.op == OP_READ) begin
                    n_out_data.read_value = rd_sel;
                end else begin
                    n_out_data.was_updated = |(rd_mark & win_onehot(r_cmd.win));
                end
                n_state = BK_RUN;
            end
            BK_CLEAR: begin
                sweep_mark = 1'b1;
                mark_we    = '1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = BK_RUN;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_data <= n_out_data;
    end

    // ram port muxing
    assign waddr      = (sweep_tbl || sweep_mark) ? r_cnt : i_cmd.off[AW-1:0];
    assign raddr      = i_cmd.off[AW-1:0];
    assign tbl_wdata  = sweep_tbl ? '0 : i_cmd.val;
    assign mark_wdata = !sweep_mark;

    // window tables
    mrm_ram #(.WIDTH(BIT_W), .DEPTH(WINDOW_DEPTH), .AW(AW)) u_coil_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we[SLOT_COIL]),
        .i_waddr (waddr),
        .i_wdata (tbl_wdata[BIT_W-1:0]),
        .i_raddr (raddr),
        .o_rdata (rd_coil)
    );

    mrm_ram #(.WIDTH(BIT_W), .DEPTH(WINDOW_DEPTH), .AW(AW)) u_disc_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we[SLOT_DISCRETE]),
        .i_waddr (waddr),
        .i_wdata (tbl_wdata[BIT_W-1:0]),
        .i_raddr (raddr),
        .o_rdata (rd_disc)
    );

    mrm_ram #(.WIDTH(REG_W), .DEPTH(WINDOW_DEPTH), .AW(AW)) u_inreg_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we[SLOT_INREG]),
        .i_waddr (waddr),
        .i_wdata (tbl_wdata[REG_W-1:0]),
        .i_raddr (raddr),
        .o_rdata (rd_inreg)
    );

    mrm_ram #(.WIDTH(REG_W), .DEPTH(WINDOW_DEPTH), .AW(AW)) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we[SLOT_HOLDING]),
        .i_waddr (waddr),
        .i_wdata (tbl_wdata[REG_W-1:0]),
        .i_raddr (raddr),
        .o_rdata (rd_hold)
    );

    // update marks, one ram per window
    for (genvar g = 0; g < NUM_WIN; g++) begin : g_mark
        mrm_ram #(.WIDTH(1), .DEPTH(WINDOW_DEPTH), .AW(AW)) u_mark_ram (
            .i_clk   (i_clk),
            .i_we    (mark_we[g]),
            .i_waddr (waddr),
            .i_wdata (mark_wdata),
            .i_raddr (raddr),
            .o_rdata (rd_mark[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/modbus_register_map_with_update_flags.sv]
// ----------------------------------------------------------------------------
// modbus_register_map_with_update_flags
// Modbus data map with four address windows and per-entry update marks.
// ----------------------------------------------------------------------------
// Each transaction is decoded against the coil, discrete input, input register
// and holding register windows (first match wins) in the cycle it is accepted
// and placed in a two-entry command queue, so the input side keeps taking
// transactions while a result waits. The execution side loads the result of a
// write, a miss or a clear at dispatch; a read or query passes a wait state for
// the registered read of the table rams. A clear then sweeps all entries of the
// update mark rams, and after reset a clearing pass zeroes all tables and
// marks; during either sweep queued transactions wait while register writes
// are still taken. Writes sustain one transaction per cycle unless the output
// stalls; a read or query holds off the next until its result is loaded.
// Window registers sit on the APB port at byte address 4*index.
// ----------------------------------------------------------------------------
module modbus_register_map_with_update_flags
    import mrm_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_map_cfg   r_cfg;
    logic       cfg_wr;
    logic [2:0] reg_idx;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_valid;
    t_cmd       front_cmd;
    t_cmd       q_cmd;

    // window registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_COIL_START:     r_cfg[SLOT_COIL].start     <= pwdata[ADDR_W-1:0];
                REG_COIL_COUNT:     r_cfg[SLOT_COIL].count     <= pwdata[COUNT_W-1:0];
                REG_DISCRETE_START: r_cfg[SLOT_DISCRETE].start <= pwdata[ADDR_W-1:0];
                REG_DISCRETE_COUNT: r_cfg[SLOT_DISCRETE].count <= pwdata[COUNT_W-1:0];
                REG_INREG_START:    r_cfg[SLOT_INREG].start    <= pwdata[ADDR_W-1:0];
                REG_INREG_COUNT:    r_cfg[SLOT_INREG].count    <= pwdata[COUNT_W-1:0];
                REG_HOLDING_START:  r_cfg[SLOT_HOLDING].start  <= pwdata[ADDR_W-1:0];
                REG_HOLDING_COUNT:  r_cfg[SLOT_HOLDING].count  <= pwdata[COUNT_W-1:0];
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_idx)
            REG_COIL_START:     prdata = PDATA_W'(r_cfg[SLOT_COIL].start);
            REG_COIL_COUNT:     prdata = PDATA_W'(r_cfg[SLOT_COIL].count);
            REG_DISCRETE_START: prdata = PDATA_W'(r_cfg[SLOT_DISCRETE].start);
            REG_DISCRETE_COUNT: prdata = PDATA_W'(r_cfg[SLOT_DISCRETE].count);
            REG_INREG_START:    prdata = PDATA_W'(r_cfg[SLOT_INREG].start);
            REG_INREG_COUNT:    prdata = PDATA_W'(r_cfg[SLOT_INREG].count);
            REG_HOLDING_START:  prdata = PDATA_W'(r_cfg[SLOT_HOLDING].start);
            REG_HOLDING_COUNT:  prdata = PDATA_W'(r_cfg[SLOT_HOLDING].count);
        endcase
    end

    // decode front
    mrm_front #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cmd      (front_cmd)
    );

    // command queue
    mrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // execution back
    mrm_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

[tb/tb_modbus_register_map_with_update_flags.sv]
// ----------------------------------------------------------------------------
// tb_modbus_register_map_with_update_flags
// Self-checking bench for the Modbus data map. Window registers are set over
// APB between phases, transactions are streamed with random gaps and output
// stalls, and every response is checked against a shadow copy of the tables,
// update marks and window decode kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_modbus_register_map_with_update_flags
    import mrm_pkg::*;
();

    localparam int DEPTH       = DEF_WINDOW_DEPTH;
    localparam int SETTLE      = DEPTH + 16;
    localparam int HOLD_CYCLES = 300;
    localparam int STUCK_LIMIT = 8 * DEPTH;
    localparam int TAIL_CYCLES = 32;

    // shadow of the data map, plus the responses still owed by the block
    class map_shadow;
        int          start_of [NUM_WIN];
        int          count_of [NUM_WIN];
        bit [15:0]   entry_value [NUM_WIN][DEPTH];
        bit          update_mark [NUM_WIN][DEPTH];
        t_out_item   expected_responses[$];
        int          mismatches;

        function void set_register(input logic [2:0] index, input logic [15:0] value);
            case (index)
                REG_COIL_START:     start_of[SLOT_COIL]     = value;
                REG_COIL_COUNT:     count_of[SLOT_COIL]     = value[COUNT_W-1:0];
                REG_DISCRETE_START: start_of[SLOT_DISCRETE] = value;
                REG_DISCRETE_COUNT: count_of[SLOT_DISCRETE] = value[COUNT_W-1:0];
                REG_INREG_START:    start_of[SLOT_INREG]    = value;
                REG_INREG_COUNT:    count_of[SLOT_INREG]    = value[COUNT_W-1:0];
                REG_HOLDING_START:  start_of[SLOT_HOLDING]  = value;
                REG_HOLDING_COUNT:  count_of[SLOT_HOLDING]  = value[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        // first window holding the address wins; counts saturate at the depth
        function t_win locate(input logic [15:0] addr, output int offset);
            int eff;
            offset = 0;
            for (int w = 0; w < NUM_WIN; w++) begin
                eff = (count_of[w] > DEPTH) ? DEPTH : count_of[w];
                if (int'(addr) >= start_of[w] && int'(addr) - start_of[w] < eff) begin
                    offset = int'(addr) - start_of[w];
                    return t_win'(w + 1);
                end
            end
            return WIN_NONE;
        endfunction

        function void note_access(input t_in_item item);
            t_out_item resp;
            t_win      win;
            int        offset;
            int        slot;
            resp = '0;
            if (t_op'(item.operation) == OP_CLEAR) begin
                foreach (update_mark[w, e]) update_mark[w][e] = 1'b0;
            end else begin
                win = locate(item.address, offset);
                resp.window_hit = win;
                if (win != WIN_NONE) begin
                    slot = int'(win) - 1;
                    case (t_op'(item.operation))
                        OP_WRITE: begin
                            if (slot == SLOT_COIL || slot == SLOT_DISCRETE)
                                entry_value[slot][offset] = {8'h00, item.write_value[7:0]};
                            else
                                entry_value[slot][offset] = item.write_value;
                            update_mark[slot][offset] = 1'b1;
                        end
                        OP_READ:  resp.read_value  = entry_value[slot][offset];
                        OP_QUERY: resp.was_updated = update_mark[slot][offset];
                        default: ;
                    endcase
                end
            end
            expected_responses.push_back(resp);
        endfunction

        function void check_response(input t_out_item got);
            t_out_item want;
            if (expected_responses.size() == 0) begin
                $display("%0t unexpected response: expected none, actual %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_responses.pop_front();
            if (got.read_value !== want.read_value) begin
                $display("%0t read_value: expected %h, actual %h",
                         $time, want.read_value, got.read_value);
                mismatches++;
            end
            if (got.window_hit !== want.window_hit) begin
                $display("%0t window_hit: expected %0d, actual %0d",
                         $time, want.window_hit, got.window_hit);
                mismatches++;
            end
            if (got.was_updated !== want.was_updated) begin
                $display("%0t was_updated: expected %b, actual %b",
                         $time, want.was_updated, got.was_updated);
                mismatches++;
            end
        endfunction

        function int pending_count();
            return expected_responses.size();
        endfunction
    endclass

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [PADDR_W-1:0] paddr       = '0;
    logic [PDATA_W-1:0] pwdata      = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    map_shadow   sb = new();
    bit          calm;
    bit          hold_req;
    int          stuck_cycles;
    logic [15:0] recent_addr [8];

    modbus_register_map_with_update_flags u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #1 i_clk = ~i_clk;

    // transaction monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stuck_cycles++;
            if (i_in_valid && !o_in_stall) begin
                sb.note_access(i_in_data);
                stuck_cycles = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                sb.check_response(o_out_data);
                stuck_cycles = 0;
            end
            if (stuck_cycles > STUCK_LIMIT) begin
                $display("tb_modbus_register_map_with_update_flags: errors");
                $finish;
            end
        end
    end

    // output side stalls: random bursts, one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    task automatic send_access(input t_in_item item);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic access(input t_op op, input int addr, input int value);
        t_in_item item;
        item.operation   = op;
        item.address     = 16'(addr);
        item.write_value = 16'(value);
        send_access(item);
    endtask

    task automatic pause_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_count() != 0);
    endtask

    // setup and access phase; the caller releases psel after the last write
    task automatic apb_write(input logic [2:0] index, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_register(index, value);
    endtask

    // reprogram all four windows once the block has gone quiet
    task automatic apply_map(input int cs, input int cc, input int ds, input int dc,
                             input int is, input int ic, input int hs, input int hc);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        apb_write(REG_COIL_START,     16'(cs));
        apb_write(REG_COIL_COUNT,     16'(cc));
        apb_write(REG_DISCRETE_START, 16'(ds));
        apb_write(REG_DISCRETE_COUNT, 16'(dc));
        apb_write(REG_INREG_START,    16'(is));
        apb_write(REG_INREG_COUNT,    16'(ic));
        apb_write(REG_HOLDING_START,  16'(hs));
        apb_write(REG_HOLDING_COUNT,  16'(hc));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random transaction, mostly aimed at windows and recently written entries
    function automatic t_in_item next_access();
        t_in_item    item;
        int          pick;
        int          w;
        int          eff;
        logic [15:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 3)       item.operation = OP_CLEAR;
        else if (pick < 38) item.operation = OP_WRITE;
        else if (pick < 70) item.operation = OP_READ;
        else                item.operation = OP_QUERY;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            addr = recent_addr[$urandom_range(0, 7)];
        end else if (pick < 85) begin
            w    = $urandom_range(0, NUM_WIN - 1);
            eff  = (sb.count_of[w] > DEPTH) ? DEPTH : sb.count_of[w];
            addr = 16'(sb.start_of[w] + $urandom_range(0, eff));
        end else begin
            addr = 16'($urandom);
        end
        if (item.operation == OP_WRITE) recent_addr[$urandom_range(0, 7)] = addr;
        item.address     = addr;
        item.write_value = 16'($urandom);
        return item;
    endfunction

    task automatic run_random(input int count, input int hold_at, input int pause_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at) hold_req = 1'b1;
            if (i == pause_at) wait_drained();
            if (!calm && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 8));
            send_access(next_access());
        end
    endtask

    initial begin
        foreach (recent_addr[k]) recent_addr[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset map: every window empty, all transactions miss
        access(OP_WRITE, 0, 'hFFFF);
        access(OP_READ, 0, 0);
        access(OP_QUERY, 'hFFFF, 0);
        access(OP_CLEAR, 'h1234, 0);

        // coil overlaps discrete, holding runs past the top with a saturated count
        apply_map(0, 8, 4, 8, 1000, 1024, 65530, 2047);
        access(OP_WRITE, 0, 'hFFFF);
        access(OP_READ, 0, 0);
        access(OP_QUERY, 0, 0);
        access(OP_QUERY, 1, 0);
        access(OP_WRITE, 5, 'hA5C3);
        access(OP_READ, 5, 0);
        access(OP_WRITE, 11, 'h1234);
        access(OP_READ, 11, 0);
        access(OP_READ, 12, 0);
        access(OP_WRITE, 1000, 'hFFFF);
        access(OP_WRITE, 2023, 'h0001);
        access(OP_READ, 2023, 0);
        access(OP_READ, 2024, 0);
        access(OP_WRITE, 65535, 'h8000);
        access(OP_READ, 65535, 0);
        access(OP_QUERY, 65535, 0);
        access(OP_WRITE, 999, 'h5555);
        access(OP_QUERY, 999, 0);
        access(OP_CLEAR, 65535, 'hFFFF);
        access(OP_QUERY, 0, 0);
        access(OP_READ, 0, 0);

        // small scattered windows, with one long output hold-off
        apply_map($urandom_range(0, 65535), $urandom_range(1, 48),
                  $urandom_range(0, 65535), $urandom_range(1, 48),
                  $urandom_range(0, 65535), $urandom_range(1, 48),
                  $urandom_range(0, 65535), $urandom_range(1, 48));
        run_random(300, 100, -1);

        // windows piled on one base, sender waits for the block to drain once
        begin
            int base;
            base = $urandom_range(0, 65535);
            apply_map(base + $urandom_range(0, 16), $urandom_range(1, 64),
                      base + $urandom_range(0, 16), $urandom_range(1, 1024),
                      base + $urandom_range(0, 16), $urandom_range(1, 1024),
                      base, $urandom_range(1, 1024));
        end
        run_random(300, -1, 120);

        // extreme starts and counts
        apply_map(0, 1024, 0, 2047, 65535, 1, 64512, 1024);
        run_random(300, -1, -1);

        apply_map(65535, 0, 0, 0, 65535, 0, 0, 2047);
        run_random(300, -1, -1);

        // fully random map, no idling on either side
        apply_map($urandom_range(0, 65535), $urandom_range(0, 2047),
                  $urandom_range(0, 65535), $urandom_range(0, 2047),
                  $urandom_range(0, 65535), $urandom_range(0, 2047),
                  $urandom_range(0, 65535), $urandom_range(0, 2047));
        calm = 1'b1;
        run_random(300, -1, -1);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb_modbus_register_map_with_update_flags: clean");
        end else begin
            $display("tb_modbus_register_map_with_update_flags: errors");
        end
        $finish;
    end

endmodule

[files.f]
rtl/mrm_pkg.sv
rtl/mrm_ram.sv
rtl/mrm_front.sv
rtl/mrm_queue.sv
rtl/mrm_back.sv
rtl/modbus_register_map_with_update_flags.sv
tb/tb_modbus_register_map_with_update_flags.sv
